// ===== rtl/contiguous_fit_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_assert.svh
// Assertion macros used by the allocator module
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// condition holds at every edge out of reset
`define CFA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("allocator check failed");
// condition in one cycle implies condition in the next
`define CFA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("allocator sequence check failed");
`else
`define CFA_ASSERT(lbl, cond)
`define CFA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/cfa_pkg.sv =====
// ----------------------------------------------------------------------------
// cfa_pkg
// Types and constants of the contiguous fit allocator
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int MEM_SIZE   = 4096;
    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BASE_W     = $clog2(MEM_SIZE);
    localparam int SIZE_W     = $clog2(MEM_SIZE + 1);
    localparam int OWNER_W    = 16;

    // request kinds
    localparam logic [1:0] REQ_ALLOC    = 2'd0;
    localparam logic [1:0] REQ_FREE     = 2'd1;
    localparam logic [1:0] REQ_COALESCE = 2'd2;

    // fit policies
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // answer codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_NO_OWN  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [SIZE_W-1:0]  size;
        logic [OWNER_W-1:0] owner;
        logic               used;
    } entry_t;

    // table operations broadcast along the cell row
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_MERGE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] k;
        entry_t           data;
    } cell_cmd_t;

endpackage

// ===== rtl/cfa_cell.sv =====
// ----------------------------------------------------------------------------
// cfa_cell
// One table entry; shifts to or from its neighbours on insert and merge
// ----------------------------------------------------------------------------
module cfa_cell
    import cfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_cmd_t        cmd,
    input  entry_t           left,
    input  entry_t           right,
    output entry_t           entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // next entry from the broadcast command
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            OP_WRITE:
            begin
                if (cell_idx == cmd.k)
                    entry_next = cmd.data;
            end
            OP_INSERT:
            begin
                if (cell_idx == cmd.k)
                    entry_next = cmd.data;
                else if (cell_idx > cmd.k)
                    entry_next = left;
            end
            OP_MERGE:
            begin
                if (cell_idx == cmd.k)
                    entry_next.size = entry_reg.size + right.size;
                else if (cell_idx > cmd.k)
                    entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry zero starts as one free block over all memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{base:  BASE_W'(0),
                           size:  (cell_idx == '0) ? SIZE_W'(MEM_SIZE) : SIZE_W'(0),
                           owner: OWNER_W'(0),
                           used:  1'b0};
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/contiguous_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Address-ordered block table with first, best and worst fit allocation
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       tuser req_type, tdata owner_id, req_size
// m_*       out  m_tvalid / m_tready       tuser status, tdata slot_idx, block_base
// cfg_*     in   cfg_we                    cfg_wdata fit_policy
//
// one item at a time: a scan over the table reads one entry per cycle; the
// result is registered after the scan and the evaluate state, and the write
// state where a block is taken or freed; best and worst fit always scan the
// whole table; coalesce walks each entry, merging it into its neighbour or stepping on
// reset gives one free block over all memory; no clearing pass
// a new item is taken at the edge after the previous result has been delivered
// ----------------------------------------------------------------------------
`include "contiguous_fit_allocator_assert.svh"

module contiguous_fit_allocator
    import cfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    input  logic [31:0] s_tdata,   // [15:0] owner_id, [28:16] req_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic [15:0] m_tdata,   // [3:0] slot_idx, [15:4] block_base
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_WRITE = 5'b01000,
        S_SPARE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          policy_reg;
    logic [1:0]          type_reg;
    logic [OWNER_W-1:0]  owner_reg;
    logic [SIZE_W-1:0]   want_reg;
    logic [CNT_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic                found_reg, found_next;
    entry_t              pick_entry_reg, pick_entry_next;
    logic                prev_free_reg, prev_free_next;
    logic                m_valid_reg;
    logic [1:0]          status_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [BASE_W-1:0]   base_reg;

    entry_t              cell_q [MAX_BLOCKS];
    cell_cmd_t           cmd;
    entry_t              rd;
    logic                s_accept;
    logic                last;
    logic                fits;
    logic                take;
    logic                first_pol;
    logic [SIZE_W-1:0]   rem;
    logic                fin;
    logic [1:0]          fin_status;
    logic [IDX_W-1:0]    fin_idx;
    logic [BASE_W-1:0]   fin_base;

    // row of table cells
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        entry_t left_e, right_e;
        if (i == 0)
        begin : g_first
            assign left_e = '0;
        end
        else
        begin : g_mid
            assign left_e = cell_q[i-1];
        end
        if (i == MAX_BLOCKS - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_up
            assign right_e = cell_q[i+1];
        end
        cfa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .cmd      (cmd),
            .left     (left_e),
            .right    (right_e),
            .entry    (cell_q[i])
        );
    end

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign s_accept = s_tvalid && s_tready;

    // entry under the scan pointer
    assign rd        = cell_q[p_reg[IDX_W-1:0]];
    assign last      = (p_reg + CNT_W'(1)) >= count_reg;
    assign fits      = !rd.used && (rd.size >= want_reg);
    assign first_pol = (policy_reg != FIT_BEST) && (policy_reg != FIT_WORST);
    assign take      = fits && (!found_reg
                       || (policy_reg == FIT_BEST  && rd.size < pick_entry_reg.size)
                       || (policy_reg == FIT_WORST && rd.size > pick_entry_reg.size));
    assign rem       = pick_entry_reg.size - want_reg;

    // request sequencer
    always_comb
    begin
        state_next      = state_reg;
        p_next          = p_reg;
        count_next      = count_reg;
        pick_next       = pick_reg;
        found_next      = found_reg;
        pick_entry_next = pick_entry_reg;
        prev_free_next  = prev_free_reg;
        cmd             = '0;
        cmd.op          = OP_HOLD;
        fin             = 1'b0;
        fin_status      = ST_OK;
        fin_idx         = '0;
        fin_base        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next     = S_SCAN;
                    p_next         = '0;
                    found_next     = 1'b0;
                    prev_free_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                case (type_reg)
                    REQ_ALLOC:
                    begin
                        if (want_reg == '0)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_NO_FIT;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            if (take)
                            begin
                                pick_next       = p_reg[IDX_W-1:0];
                                pick_entry_next = rd;
                                found_next      = 1'b1;
                            end
                            p_next = p_reg + CNT_W'(1);
                            if (last || (fits && first_pol))
                                state_next = S_EVAL;
                        end
                    end
                    REQ_FREE:
                    begin
                        if (rd.used && rd.owner == owner_reg)
                        begin
                            pick_next       = p_reg[IDX_W-1:0];
                            pick_entry_next = rd;
                            found_next      = 1'b1;
                            state_next      = S_EVAL;
                        end
                        else
                        begin
                            p_next = p_reg + CNT_W'(1);
                            if (last)
                                state_next = S_EVAL;
                        end
                    end
                    REQ_COALESCE:
                    begin
                        if (p_reg >= count_reg)
                        begin
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                        else if (prev_free_reg && !rd.used)
                        begin
                            cmd.op     = OP_MERGE;
                            cmd.k      = IDX_W'(p_reg - CNT_W'(1));
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            prev_free_next = !rd.used;
                            p_next         = p_reg + CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EVAL:
            begin
                if (!found_reg)
                begin
                    fin        = 1'b1;
                    fin_status = (type_reg == REQ_FREE) ? ST_NO_OWN : ST_NO_FIT;
                    state_next = S_IDLE;
                end
                else if (type_reg == REQ_ALLOC && rem != '0)
                begin
                    if (count_reg == CNT_W'(MAX_BLOCKS))
                    begin
                        fin        = 1'b1;
                        fin_status = ST_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // split off the remainder behind the chosen block
                        cmd.op         = OP_INSERT;
                        cmd.k          = pick_reg + IDX_W'(1);
                        cmd.data.base  = pick_entry_reg.base + BASE_W'(want_reg);
                        cmd.data.size  = rem;
                        cmd.data.owner = '0;
                        cmd.data.used  = 1'b0;
                        count_next     = count_reg + CNT_W'(1);
                        state_next     = S_WRITE;
                    end
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.op   = OP_WRITE;
                cmd.k    = pick_reg;
                cmd.data = pick_entry_reg;
                if (type_reg == REQ_ALLOC)
                begin
                    cmd.data.size  = want_reg;
                    cmd.data.owner = owner_reg;
                    cmd.data.used  = 1'b1;
                end
                else
                begin
                    cmd.data.used = 1'b0;
                end
                fin        = 1'b1;
                fin_idx    = pick_reg;
                fin_base   = pick_entry_reg.base;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= '0;
            count_reg     <= CNT_W'(1);
            m_valid_reg   <= 1'b0;
            p_reg         <= '0;
            found_reg     <= 1'b0;
            prev_free_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            p_reg         <= p_next;
            found_reg     <= found_next;
            prev_free_reg <= prev_free_next;
            if (cfg_we)
                policy_reg <= cfg_wdata;
            if (fin)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        pick_entry_reg <= pick_entry_next;
        if (s_accept)
        begin
            type_reg  <= s_tuser;
            owner_reg <= s_tdata[15:0];
            want_reg  <= s_tdata[28:16];
        end
        if (fin)
        begin
            status_reg <= fin_status;
            idx_reg    <= fin_idx;
            base_reg   <= fin_base;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {base_reg, idx_reg};

    `CFA_ASSERT(a_count_range, count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
    `CFA_ASSERT_NEXT(a_accept_scan, s_accept, state_reg == S_SCAN)
    `CFA_ASSERT(a_write_found, state_reg != S_WRITE || found_reg)
    `CFA_ASSERT_NEXT(a_fin_valid, fin, m_valid_reg && state_reg == S_IDLE)

endmodule
